### hdl/ais_pkg.sv
// ----------------------------------------------------------------------------
// ais_pkg
// Shared types and constants for the ascending integer sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package ais_pkg;

    localparam int VALUE_W        = 32;
    localparam int CAPACITY_DEF   = 64;
    localparam int ELEM_WIDTH_DEF = 32;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } t_state;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hdl/ais_if.sv
// ----------------------------------------------------------------------------
// ais_if
// Valid/ready stream interfaces for sorter requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ais_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface ais_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_res;
    logic        last_res;
    logic        overflow;

    modport source (output valid, output value_res, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input value_res, input last_res, input overflow,
                    output ready);
endinterface

`default_nettype wire

### hdl/ais_cell.sv
// ----------------------------------------------------------------------------
// ais_cell
// One slot of the insertion chain: holds one element and a valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ais_cell #(
    parameter int ELEM_WIDTH = ais_pkg::ELEM_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  ais_pkg::t_cell_ctl       i_ctl,
    input  wire  [ELEM_WIDTH-1:0]    i_key,
    input  wire  [ELEM_WIDTH-1:0]    i_prev_val,
    input  wire                      i_prev_vld,
    input  wire  [ELEM_WIDTH-1:0]    i_next_val,
    input  wire                      i_next_vld,
    output logic [ELEM_WIDTH-1:0]    o_val,
    output logic                     o_vld
);
    import ais_pkg::*;

    logic [ELEM_WIDTH-1:0] r_val, n_val;
    logic                  r_vld, n_vld;
    logic                  w_key_lt_own;
    logic                  w_key_lt_prev;

    assign w_key_lt_own  = $signed(i_key) < $signed(r_val);
    assign w_key_lt_prev = $signed(i_key) < $signed(i_prev_val);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.insert) begin
            // chain stays sorted: larger neighbors move up one slot
            if (i_prev_vld && w_key_lt_prev) begin
                n_val = i_prev_val;
                n_vld = 1'b1;
            end else if ((!r_vld && i_prev_vld) || (r_vld && w_key_lt_own)) begin
                // an empty slot takes the key only right behind the filled part
                n_val = i_key;
                n_vld = 1'b1;
            end
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
            n_vld = i_next_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

`default_nettype wire

### hdl/ascending_integer_sorter_core.sv
// Collect: one request accepted per cycle, inserted in order (dropped if full).
// Drain: first result is valid the cycle after the request marked last and
//   results then leave one per cycle, while ready is high, from the chain head.
// No request is taken while a set drains; back to collect after the final result.
// Reset (synchronous, active low) clears the valid bits, drop flag and state;
//   the element registers themselves are not cleared.
// ----------------------------------------------------------------------------
// ascending_integer_sorter_core
// Insertion-chain sorter: keeps a set in ascending order, then streams it out.
// ----------------------------------------------------------------------------
`default_nettype none

module ascending_integer_sorter_core #(
    parameter int CAPACITY   = ais_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = ais_pkg::ELEM_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ais_in_if.sink      i_req,
    ais_out_if.source   o_res
);
    import ais_pkg::*;

    localparam int KEY_W = (ELEM_WIDTH < VALUE_W) ? ELEM_WIDTH : VALUE_W;

    t_state                r_state, n_state;
    logic                  r_drop, n_drop;
    t_cell_ctl             w_ctl;
    logic [ELEM_WIDTH-1:0] w_key;
    logic [ELEM_WIDTH-1:0] w_val [CAPACITY];
    logic                  w_vld [CAPACITY];
    logic                  w_full;
    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_last_res;

    assign w_key      = ELEM_WIDTH'($signed(i_req.value[KEY_W-1:0]));
    assign w_full     = w_vld[CAPACITY-1];
    assign w_last_res = !w_vld[1];
    assign w_in_acc   = i_req.valid && i_req.ready;
    assign w_out_acc  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drop  <= n_drop;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_drop       = r_drop;
        w_ctl.insert = 1'b0;
        w_ctl.shift  = 1'b0;
        i_req.ready  = 1'b0;
        o_res.valid  = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                i_req.ready = 1'b1;
                if (w_in_acc) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        w_ctl.insert = 1'b1;
                    end
                    if (i_req.last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                o_res.valid = 1'b1;
                if (w_out_acc) begin
                    w_ctl.shift = 1'b1;
                    if (w_last_res) begin
                        n_state = ST_COLLECT;
                        n_drop  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ELEM_WIDTH-1:0] w_prev_val, w_next_val;
        logic                  w_prev_vld, w_next_vld;

        if (g == 0) begin : g_head
            // head sees a filled neighbor holding the minimum: never shifts in,
            // and takes the key when empty
            assign w_prev_val = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
            assign w_prev_vld = 1'b1;
        end else begin : g_body
            assign w_prev_val = w_val[g-1];
            assign w_prev_vld = w_vld[g-1];
        end

        if (g == CAPACITY-1) begin : g_tail
            assign w_next_val = '0;
            assign w_next_vld = 1'b0;
        end else begin : g_link
            assign w_next_val = w_val[g+1];
            assign w_next_vld = w_vld[g+1];
        end

        ais_cell #(
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (w_key),
            .i_prev_val (w_prev_val),
            .i_prev_vld (w_prev_vld),
            .i_next_val (w_next_val),
            .i_next_vld (w_next_vld),
            .o_val      (w_val[g]),
            .o_vld      (w_vld[g])
        );
    end

    assign o_res.value_res = VALUE_W'($signed(w_val[0]));
    assign o_res.last_res  = w_last_res;
    assign o_res.overflow  = r_drop;

endmodule

`default_nettype wire

### hdl/ais_checker.sv
// ----------------------------------------------------------------------------
// ais_checker
// Port-level checks of the sorter's collect/drain sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module ais_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_in_last,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_out_last,
    input wire i_out_overflow
);

    // requests are never taken while a set drains
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("request ready while results pending");

    a_drain_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> i_out_valid)
        else $error("no result after final request");

    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_out_last) |=> (i_in_ready && !i_out_valid))
        else $error("sorter did not return to collect after final result");

    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && $past(i_out_valid)) |-> (i_out_overflow == $past(i_out_overflow)))
        else $error("overflow flag changed within a result run");

endmodule

bind ascending_integer_sorter_core ais_checker u_ais_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_in_last      (i_req.last),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_last     (o_res.last_res),
    .i_out_overflow (o_res.overflow)
);

`default_nettype wire
